// File: sv/sodfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the send-on-delta four-count decimator.
// No dependencies; imported by every module of the block.
package sodfc_pkg;

  localparam int NUM_COUNTS    = 4;
  localparam int TAG_BITS      = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  // word index of each register (byte address / 4)
  localparam logic CFG_IDX_CHANGE_FRACTION = 1'b0;

  localparam int CHANGE_FRACTION_RESET = 655;

endpackage

// File: sv/send_on_delta_four_count_decimator_unit.sv
`timescale 1ns / 1ps
// Top level of the send-on-delta four-count decimator.
// Depends on sodfc_pkg, sodfc_cfg, sodfc_in_stage, sodfc_eval.
//
//  port group | dir | handshake            | payload
//  in_*       | in  | tvalid/tready        | tdata: count_s, count_e, count_i, count_r, tag
//  out_*      | out | tvalid/tready        | tdata: kept_s, kept_e, kept_i, kept_r, kept_tag
//  cfg_*      | in  | psel/penable/pready  | change_fraction at byte address 0
//
// One request per cycle unless a held result stalls; registered at input and result.
// The first request after reset latches the threshold with one multiply.
// A held result stalls only requests that would emit; dropped ones pass.
// rst_n is synchronous; the first request after it is always emitted.
module send_on_delta_four_count_decimator_unit import sodfc_pkg::*; #(
  parameter int  COUNT_BITS    = 24,
  parameter int  FRACTION_BITS = 16,
  localparam int TDATA_BITS    = ((NUM_COUNTS * COUNT_BITS + TAG_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // count_s, count_e, count_i, count_r, record_tag (lowest first)
  input  logic [TDATA_BITS-1:0]    in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // kept_s, kept_e, kept_i, kept_r, kept_tag (lowest first)
  output logic [TDATA_BITS-1:0]    out_tdata,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int TAG_LSB = NUM_COUNTS * COUNT_BITS;

  logic [FRACTION_BITS:0]                change_fraction;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] in_counts;
  logic [TAG_BITS-1:0]                   in_tag;
  logic                                  hold_valid;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] hold_counts;
  logic [TAG_BITS-1:0]                   hold_tag;
  logic [COUNT_BITS+1:0]                 hold_total;
  logic                                  advance;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] out_counts;
  logic [TAG_BITS-1:0]                   out_tag;

  always_comb begin
    for (int k = 0; k < NUM_COUNTS; k++) begin
      in_counts[k] = in_tdata[k*COUNT_BITS +: COUNT_BITS];
    end
    in_tag = in_tdata[TAG_LSB +: TAG_BITS];
  end

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NUM_COUNTS; k++) begin
      out_tdata[k*COUNT_BITS +: COUNT_BITS] = out_counts[k];
    end
    out_tdata[TAG_LSB +: TAG_BITS] = out_tag;
  end

  sodfc_cfg #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .change_fraction(change_fraction)
  );

  sodfc_in_stage #(
    .COUNT_BITS(COUNT_BITS)
  ) u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_counts  (in_counts),
    .in_tag     (in_tag),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_counts(hold_counts),
    .hold_tag   (hold_tag),
    .hold_total (hold_total)
  );

  sodfc_eval #(
    .COUNT_BITS   (COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (hold_valid),
    .item_counts    (hold_counts),
    .item_tag       (hold_tag),
    .item_total     (hold_total),
    .change_fraction(change_fraction),
    .advance        (advance),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_counts     (out_counts),
    .out_tag        (out_tag)
  );

endmodule

// File: sv/sodfc_cfg.sv
`timescale 1ns / 1ps
// APB-style register file holding the change_fraction register.
// Depends on sodfc_pkg.
module sodfc_cfg import sodfc_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [FRACTION_BITS:0]   change_fraction
);

  logic [FRACTION_BITS:0] change_fraction_r;
  logic [FRACTION_BITS:0] change_fraction_nxt;
  logic                   wr_hit;
  logic                   word_idx;

  assign pready   = 1'b1;
  assign word_idx = paddr[CFG_ADDR_BITS-1];
  assign wr_hit   = psel && penable && pwrite && pready &&
                    (word_idx == CFG_IDX_CHANGE_FRACTION);

  always_comb begin
    change_fraction_nxt = change_fraction_r;
    if (wr_hit) begin
      change_fraction_nxt = pwdata[FRACTION_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_fraction_r <= (FRACTION_BITS+1)'(CHANGE_FRACTION_RESET);
    end else begin
      change_fraction_r <= change_fraction_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (word_idx)
      CFG_IDX_CHANGE_FRACTION: prdata[FRACTION_BITS:0] = change_fraction_r;
      default:                 prdata = '0;
    endcase
  end

  assign change_fraction = change_fraction_r;

endmodule

// File: sv/sodfc_in_stage.sv
`timescale 1ns / 1ps
// Input register: holds one request and the sum of its four counts.
// Depends on sodfc_pkg.
module sodfc_in_stage import sodfc_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] in_counts,
  input  logic [TAG_BITS-1:0]                   in_tag,
  input  logic                                  advance,
  output logic                                  hold_valid,
  output logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] hold_counts,
  output logic [TAG_BITS-1:0]                   hold_tag,
  output logic [COUNT_BITS+1:0]                 hold_total
);

  logic                                  valid_r;
  logic                                  valid_nxt;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] counts_r;
  logic [TAG_BITS-1:0]                   tag_r;
  logic [COUNT_BITS+1:0]                 total_r;
  logic [COUNT_BITS+1:0]                 total_nxt;
  logic                                  take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    total_nxt = (COUNT_BITS+2)'(in_counts[0]) + (COUNT_BITS+2)'(in_counts[1]) +
                (COUNT_BITS+2)'(in_counts[2]) + (COUNT_BITS+2)'(in_counts[3]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      counts_r <= in_counts;
      tag_r    <= in_tag;
      total_r  <= total_nxt;
    end
  end

  assign hold_valid  = valid_r;
  assign hold_counts = counts_r;
  assign hold_tag    = tag_r;
  assign hold_total  = total_r;

endmodule

// File: sv/sodfc_eval.sv
`timescale 1ns / 1ps
// Deadband decision, reference and threshold state, and result register.
// Depends on sodfc_pkg.
module sodfc_eval import sodfc_pkg::*; #(
  parameter int COUNT_BITS    = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  item_valid,
  input  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] item_counts,
  input  logic [TAG_BITS-1:0]                   item_tag,
  input  logic [COUNT_BITS+1:0]                 item_total,
  input  logic [FRACTION_BITS:0]                change_fraction,
  output logic                                  advance,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] out_counts,
  output logic [TAG_BITS-1:0]                   out_tag
);

  localparam int THR_BITS  = COUNT_BITS + 2;
  localparam int PROD_BITS = THR_BITS + FRACTION_BITS + 1;
  localparam logic [FRACTION_BITS:0] FracOne = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                                  first_pending_r;
  logic                                  first_pending_nxt;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] ref_r;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] ref_nxt;
  logic [THR_BITS-1:0]                   thr_r;
  logic [THR_BITS-1:0]                   thr_nxt;
  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] out_counts_r;
  logic [TAG_BITS-1:0]                   out_tag_r;

  logic [FRACTION_BITS:0]                frac;
  logic [PROD_BITS-1:0]                  prod;
  logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] gap;
  logic                                  hit;
  logic                                  emit;
  logic                                  fire;

  always_comb begin
    frac = (change_fraction > FracOne) ? FracOne : change_fraction;
    prod = PROD_BITS'(item_total) * PROD_BITS'(frac);
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_COUNTS; k++) begin
      gap[k] = (item_counts[k] >= ref_r[k]) ? (item_counts[k] - ref_r[k])
                                            : (ref_r[k] - item_counts[k]);
      if (THR_BITS'(gap[k]) > thr_r) begin
        hit = 1'b1;
      end
    end
  end

  assign emit    = first_pending_r || hit;
  assign advance = item_valid && (!emit || !out_valid_r || out_ready);
  assign fire    = advance;

  always_comb begin
    first_pending_nxt = first_pending_r;
    thr_nxt           = thr_r;
    ref_nxt           = ref_r;
    out_valid_nxt     = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire && first_pending_r) begin
      first_pending_nxt = 1'b0;
      thr_nxt           = prod[FRACTION_BITS +: THR_BITS];
    end
    if (fire && emit) begin
      ref_nxt       = item_counts;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pending_r <= 1'b1;
      thr_r           <= '0;
      ref_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      first_pending_r <= first_pending_nxt;
      thr_r           <= thr_nxt;
      ref_r           <= ref_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_counts_r <= item_counts;
      out_tag_r    <= item_tag;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_counts = out_counts_r;
  assign out_tag    = out_tag_r;

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && first_pending_r |=> !first_pending_r)
    else $error("first request did not clear first_pending");

  a_thr_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !first_pending_r |=> $stable(thr_r))
    else $error("threshold changed after it was latched");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |=> out_valid_r)
    else $error("emitted request missing from result register");

  a_drop_keeps_ref: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !emit |=> $stable(ref_r))
    else $error("reference moved on a dropped request");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(fire && emit))
    else $error("stalled result overwritten");

endmodule
